FILE: rtl/button_press_classifier_macros.svh
// Assertion macros shared by the button press classifier RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every clock edge outside reset
`define BPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("button_press_classifier check failed");

// Check that a condition implies a consequence in the next cycle
`define BPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("button_press_classifier check failed");

`else

`define BPC_ASSERT(lbl, clk, rstn, prop)
`define BPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/bpc_pkg.sv
// Package for the button press classifier: widths, event codes, lane event type.
// No dependencies; every other file but the macro header imports it.
`default_nettype none

package bpc_pkg;

  // Default number of buttons (one lane each)
  localparam int unsigned NUM_BUTTONS_DEF = 4;

  // Field widths of the channels
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned INDEX_W = 2;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned COUNT_W = 16;

  // Hold counter limits and threshold reset value
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [COUNT_W-1:0] THRESHOLD_RST = COUNT_W'(20);
  localparam logic [COUNT_W-1:0] THRESHOLD_MIN = COUNT_W'(1);

  // Holding events repeat every HOLD_PERIOD ticks; a residue counter tracks it
  localparam int unsigned HOLD_PERIOD = 10;
  localparam int unsigned RESID_W     = $clog2(HOLD_PERIOD);
  localparam logic [RESID_W-1:0] RESID_LAST = RESID_W'(HOLD_PERIOD - 1);

  typedef enum logic [KIND_W-1:0] {
    EV_SHORT_PRESS   = 3'd0,
    EV_LONG_PRESS    = 3'd1,
    EV_HOLDING       = 3'd2,
    EV_SHORT_RELEASE = 3'd3,
    EV_LONG_RELEASE  = 3'd4
  } event_kind_e;

  // Event found by one lane for one tick
  typedef struct packed {
    logic               valid;
    event_kind_e        kind;
    logic [COUNT_W-1:0] count;
  } bpc_event_t;

endpackage

`default_nettype wire

FILE: rtl/bpc_tick_if.sv
// Input channel of the button press classifier: one poll tick per beat.
// Depends on bpc_pkg.
`default_nettype none

interface bpc_tick_if import bpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] released_levels;

  modport source (output valid, output released_levels, input ready);
  modport sink   (input valid, input released_levels, output ready);
endinterface

`default_nettype wire

FILE: rtl/bpc_event_if.sv
// Output channel of the button press classifier: one button event per beat.
// Depends on bpc_pkg.
`default_nettype none

interface bpc_event_if import bpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] button_index;
  logic [KIND_W-1:0]  event_kind;
  logic [COUNT_W-1:0] hold_count;
  logic               last;

  modport source (output valid, output button_index, output event_kind,
                  output hold_count, output last, input ready);
  modport sink   (input valid, input button_index, input event_kind,
                  input hold_count, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/bpc_cfg_if.sv
// Configuration write channel: carries the long press threshold.
// Depends on bpc_pkg.
`default_nettype none

interface bpc_cfg_if import bpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] long_press_threshold;

  modport source (output valid, output long_press_threshold, input ready);
  modport sink   (input valid, input long_press_threshold, output ready);
endinterface

`default_nettype wire

FILE: rtl/button_press_classifier.sv
// Top level of the button press classifier: threshold register, button lanes
// and merge stage. Depends on bpc_pkg, the channel interfaces, bpc_lane, bpc_merge.
//
// Each tick beat carries the levels of all buttons (1 released, 0 pressed).
// Every button has its own lane that classifies the tick in the cycle it is
// accepted and updates that button's hold counter; the merge stage then sends
// the resulting events, lowest button first, one beat per cycle while evt_o
// is ready, with last set on the final event of the tick. The next tick is
// taken in the same cycle as the previous tick's last beat, so a tick with
// at most one event is accepted every cycle while evt_o is ready. Threshold
// writes are always ready; a written value of zero acts as one. Hold
// counters clear at reset.
`default_nettype none

module button_press_classifier import bpc_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  bpc_cfg_if.sink      cfg_i,
  bpc_tick_if.sink     tick_i,
  bpc_event_if.source  evt_o
);

  logic [COUNT_W-1:0] thr_q;
  logic [COUNT_W-1:0] thr_eff;
  logic               load;
  logic               load_ready;
  bpc_event_t         lane_evt [NUM_BUTTONS];

  // Threshold register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      thr_q <= cfg_i.long_press_threshold;
    end
  end

  assign thr_eff = (thr_q == '0) ? THRESHOLD_MIN : thr_q;

  // Accept a tick when the merge stage can take its events
  assign tick_i.ready = load_ready;
  assign load         = tick_i.valid && load_ready;

  // One lane per button; buttons beyond the input width read as pressed
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    logic released;
    if (g < LEVEL_W) begin : g_wired
      assign released = tick_i.released_levels[g];
    end else begin : g_tied
      assign released = 1'b0;
    end

    bpc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (load),
      .released_i (released),
      .thr_i      (thr_eff),
      .evt_o      (lane_evt[g])
    );
  end

  bpc_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .lane_evt_i     (lane_evt),
    .load_ready_o   (load_ready),
    .valid_o        (evt_o.valid),
    .ready_i        (evt_o.ready),
    .button_index_o (evt_o.button_index),
    .event_kind_o   (evt_o.event_kind),
    .hold_count_o   (evt_o.hold_count),
    .last_o         (evt_o.last)
  );

endmodule

`default_nettype wire

FILE: rtl/bpc_lane.sv
// One button lane: hold counter, mod-10 residue and event classification.
// Depends on bpc_pkg and the assertion macros.
`default_nettype none

`include "button_press_classifier_macros.svh"

module bpc_lane import bpc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire logic               released_i,
  input  wire logic [COUNT_W-1:0] thr_i,
  output bpc_event_t              evt_o
);

  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [RESID_W-1:0] res_q, res_d;

  // Classify against the count before this tick, then advance or clear it
  always_comb begin
    evt_o.valid = 1'b0;
    evt_o.kind  = EV_SHORT_PRESS;
    evt_o.count = '0;
    cnt_d       = cnt_q;
    res_d       = res_q;
    if (released_i) begin
      if (cnt_q >= thr_i) begin
        evt_o.valid = 1'b1;
        evt_o.kind  = EV_LONG_RELEASE;
        evt_o.count = cnt_q;
      end else if (cnt_q != '0) begin
        evt_o.valid = 1'b1;
        evt_o.kind  = EV_SHORT_RELEASE;
      end
      cnt_d = '0;
      res_d = '0;
    end else begin
      if (cnt_q == '0) begin
        evt_o.valid = 1'b1;
        evt_o.kind  = EV_SHORT_PRESS;
      end else if (cnt_q == thr_i) begin
        evt_o.valid = 1'b1;
        evt_o.kind  = EV_LONG_PRESS;
        evt_o.count = cnt_q;
      end else if ((cnt_q > thr_i) && (res_q == '0)) begin
        evt_o.valid = 1'b1;
        evt_o.kind  = EV_HOLDING;
        evt_o.count = cnt_q;
      end
      // Saturate: the residue freezes with the count
      if (cnt_q != COUNT_MAX) begin
        cnt_d = cnt_q + COUNT_W'(1);
        res_d = (res_q == RESID_LAST) ? '0 : res_q + RESID_W'(1);
      end
    end
  end

  // Commit the counter on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      res_q <= '0;
    end else if (load_i) begin
      cnt_q <= cnt_d;
      res_q <= res_d;
    end
  end

  `BPC_ASSERT(a_res_range, clk_i, rst_ni, res_q <= RESID_LAST)
  `BPC_ASSERT_NEXT(a_release_clears, clk_i, rst_ni, load_i && released_i,
                   (cnt_q == '0) && (res_q == '0))
  `BPC_ASSERT_NEXT(a_hold_advances, clk_i, rst_ni,
                   load_i && !released_i && (cnt_q != COUNT_MAX),
                   cnt_q == $past(cnt_q) + COUNT_W'(1))

endmodule

`default_nettype wire

FILE: rtl/bpc_merge.sv
// Merge stage: holds the lane events of one tick and sends them out in
// button order, one beat per cycle while ready_i is high. Depends on bpc_pkg and the macros.
`default_nettype none

`include "button_press_classifier_macros.svh"

module bpc_merge import bpc_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire bpc_event_t         lane_evt_i [NUM_BUTTONS],
  output logic                    load_ready_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [INDEX_W-1:0]      button_index_o,
  output logic [KIND_W-1:0]       event_kind_o,
  output logic [COUNT_W-1:0]      hold_count_o,
  output logic                    last_o
);

  logic [NUM_BUTTONS-1:0] pend_q, pend_d;
  logic [NUM_BUTTONS-1:0] sel_oh;
  logic [NUM_BUTTONS-1:0] new_mask;
  logic [NUM_BUTTONS-1:0] rest;
  bpc_event_t             evt_q [NUM_BUTTONS];
  bpc_event_t             sel_evt;
  logic [INDEX_W-1:0]     sel_btn;
  logic                   take;

  // Pick the lowest pending button
  always_comb begin
    sel_oh  = '0;
    sel_evt = evt_q[0];
    sel_btn = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_oh  = '0;
        sel_oh[i] = 1'b1;
        sel_evt = evt_q[i];
        sel_btn = INDEX_W'(i);
      end
    end
  end

  // Gather the valid flags of a fresh tick
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      new_mask[i] = lane_evt_i[i].valid;
    end
  end

  assign rest           = pend_q & ~sel_oh;
  assign valid_o        = |pend_q;
  assign last_o         = (rest == '0);
  assign take           = valid_o && ready_i;
  assign load_ready_o   = !valid_o || (ready_i && last_o);
  assign button_index_o = sel_btn;
  assign event_kind_o   = sel_evt.kind;
  assign hold_count_o   = sel_evt.count;

  // Drop the sent event, or reload on a new tick
  always_comb begin
    pend_d = pend_q;
    if (take) begin
      pend_d = rest;
    end
    if (load_i) begin
      pend_d = new_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Hold the event payload of the current tick
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      evt_q <= lane_evt_i;
    end
  end

  `BPC_ASSERT(a_last_single, clk_i, rst_ni, !(valid_o && last_o) || $onehot(pend_q))
  `BPC_ASSERT_NEXT(a_more_follow, clk_i, rst_ni, take && !last_o && !load_i, valid_o)
  `BPC_ASSERT(a_load_when_free, clk_i, rst_ni, !load_i || !valid_o || (take && last_o))

endmodule

`default_nettype wire
